FILE: rtl/ria_pkg.sv
// Shared widths, register indexes and types for the ray/annulus intersection unit.
package ria_pkg;

	// Dividend, divisor and quotient widths of the offset divider.
	localparam int NUM_W   = 70;
	localparam int DEN_W   = 36;
	localparam int QB      = 35;
	localparam int DIV_LAT = QB + 1;

	typedef enum logic [2:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_CENTER_Z       = 3'd2,
		REG_PLANE_NORMAL_X = 3'd3,
		REG_PLANE_NORMAL_Y = 3'd4,
		REG_PLANE_NORMAL_Z = 3'd5,
		REG_OUTER_RADIUS   = 3'd6,
		REG_INNER_RADIUS   = 3'd7
	} reg_idx_t;

	// Side information that rides alongside the divider.
	typedef struct packed {
		logic               rej;
		logic               back;
		logic [2:0]         dneg;
		logic signed [31:0] st_x;
		logic signed [31:0] st_y;
		logic signed [31:0] st_z;
	} side_t;

endpackage

FILE: rtl/ray_annulus_intersect_unit.sv
// Top level of the ray/annulus intersection pipeline.
//
//   channel | signals                        | handshake
//   in      | start_*, dir_*                 | in_valid / in_ready
//   out     | hit, point_*, facing_*         | out_valid / out_ready
//   config  | wr_index, wr_data              | wr_en, no wait
//
// One ray enters per cycle while the output is not stalled; most of the pipeline is the 36-stage offset divider.
// All stages advance together whenever the output register is empty or being taken.
// A stall freezes every stage, so no word is lost or repeated.
// Reset clears valid bits and loads the register reset values.
module ray_annulus_intersect_unit
	import ria_pkg::*;
#(
	parameter int EPSILON_RAW = 1,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [17:0] facing_x,
	output logic signed [17:0] facing_y,
	output logic signed [17:0] facing_z
);

	localparam logic [63:0] EPS   = 64'(EPSILON_RAW) << FRAC_BITS;
	localparam logic [16:0] EPS_K = 17'(EPSILON_RAW);

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		logic signed [36:0] hi;
		logic signed [36:0] lo;
		hi = 37'sd2147483647;
		lo = -37'sd2147483648;
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [17:0] neg_sat(input logic signed [17:0] v);
		if (v == -18'sd131072) return 18'sd131071;
		return -v;
	endfunction

	logic signed [31:0] center_q [3];
	logic signed [17:0] nrm_q    [3];
	logic [30:0]        outer_q;
	logic [30:0]        inner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			nrm_q[0]    <= '0;
			nrm_q[1]    <= '0;
			nrm_q[2]    <= 18'sd65536;
			outer_q     <= 31'd65536;
			inner_q     <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_CENTER_X:       center_q[0] <= wr_data;
				REG_CENTER_Y:       center_q[1] <= wr_data;
				REG_CENTER_Z:       center_q[2] <= wr_data;
				REG_PLANE_NORMAL_X: nrm_q[0]    <= wr_data[17:0];
				REG_PLANE_NORMAL_Y: nrm_q[1]    <= wr_data[17:0];
				REG_PLANE_NORMAL_Z: nrm_q[2]    <= wr_data[17:0];
				REG_OUTER_RADIUS:   outer_q     <= wr_data[30:0];
				REG_INNER_RADIUS:   inner_q     <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic signed [31:0] st_in  [3];
	logic signed [17:0] dir_in [3];
	assign st_in[0]  = start_x;
	assign st_in[1]  = start_y;
	assign st_in[2]  = start_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic vd_s [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) vd_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			vd_s[0] <= v_s6;
			for (int k = 1; k < DIV_LAT; k++) vd_s[k] <= vd_s[k-1];
			v_s7 <= vd_s[DIV_LAT-1];
			v_s8 <= v_s7;
			out_valid <= v_s8;
		end
	end

	// Stages 1 to 3: offset from center, dot products with the normal.
	logic signed [31:0] st_s1 [3], st_s2 [3], st_s3 [3], st_s4 [3], st_s5 [3], st_s6 [3];
	logic signed [17:0] dir_s1 [3], dir_s2 [3], dir_s3 [3], dir_s4 [3], dir_s5 [3];
	logic [2:0]         dneg_s6;
	logic signed [32:0] p_s1  [3];
	logic signed [50:0] pn_s2 [3];
	logic signed [35:0] dn_s2 [3];
	logic signed [52:0] ptn_s3;
	logic signed [36:0] dtn_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				st_s1[i]  <= st_in[i];
				dir_s1[i] <= dir_in[i];
				p_s1[i]   <= 33'(st_in[i]) - 33'(center_q[i]);
				st_s2[i]  <= st_s1[i];
				dir_s2[i] <= dir_s1[i];
				pn_s2[i]  <= p_s1[i] * nrm_q[i];
				dn_s2[i]  <= dir_s1[i] * nrm_q[i];
				st_s3[i]  <= st_s2[i];
				dir_s3[i] <= dir_s2[i];
			end
			ptn_s3 <= 53'(pn_s2[0]) + 53'(pn_s2[1]) + 53'(pn_s2[2]);
			dtn_s3 <= 37'(dn_s2[0]) + 37'(dn_s2[1]) + 37'(dn_s2[2]);
		end
	end

	// Stage 4: magnitudes and the zero, epsilon and sign-based rejections.
	logic [52:0] abs_p;
	logic [36:0] abs_d;
	logic        rej_c4;
	assign abs_p  = ptn_s3[52] ? 53'(-ptn_s3) : 53'(ptn_s3);
	assign abs_d  = dtn_s3[36] ? 37'(-dtn_s3) : 37'(dtn_s3);
	assign rej_c4 = (dtn_s3 == '0) || (64'(abs_d) < EPS) || (64'(abs_p) < EPS)
		|| (ptn_s3 == '0) || (ptn_s3[52] == dtn_s3[36]);

	logic [51:0] aptn_s4;
	logic [35:0] adtn_s4, adtn_s5, adtn_s6;
	logic        rej_s4, rej_s5, rej_s6;
	logic        back_s4, back_s5, back_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			aptn_s4 <= abs_p[51:0];
			adtn_s4 <= abs_d[35:0];
			rej_s4  <= rej_c4;
			back_s4 <= !dtn_s3[36];
			for (int i = 0; i < 3; i++) begin
				st_s4[i]  <= st_s3[i];
				dir_s4[i] <= dir_s3[i];
			end
		end
	end

	// Stages 5 and 6: too-near test, split products of |ptn| with |dir|, and their recombination.
	logic        near_c5;
	logic [17:0] mdir [3];
	assign near_c5 = ({28'b0, aptn_s4} << FRAC_BITS) < (80'(EPS_K) * 80'(adtn_s4));
	for (genvar i = 0; i < 3; i++) begin : g_mdir
		assign mdir[i] = dir_s4[i][17] ? 18'(-dir_s4[i]) : 18'(dir_s4[i]);
	end

	logic [43:0] pl_s5 [3];
	logic [43:0] ph_s5 [3];
	logic [NUM_W-1:0] num_s6 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			adtn_s5 <= adtn_s4;
			rej_s5  <= rej_s4 || near_c5;
			back_s5 <= back_s4;
			for (int i = 0; i < 3; i++) begin
				st_s5[i]  <= st_s4[i];
				dir_s5[i] <= dir_s4[i];
				pl_s5[i]  <= aptn_s4[25:0] * mdir[i];
				ph_s5[i]  <= aptn_s4[51:26] * mdir[i];
			end
			adtn_s6 <= adtn_s5;
			rej_s6  <= rej_s5;
			back_s6 <= back_s5;
			for (int i = 0; i < 3; i++) begin
				st_s6[i]   <= st_s5[i];
				dneg_s6[i] <= dir_s5[i][17];
				num_s6[i]  <= (NUM_W'(ph_s5[i]) << 26) + NUM_W'(pl_s5[i]);
			end
		end
	end

	// Offset dividers and matching side delay line.
	logic [QB-1:0] quo [3];
	logic          ovf [3];
	for (genvar i = 0; i < 3; i++) begin : g_div
		ria_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[i]),
			.den (adtn_s6),
			.quo (quo[i]),
			.ovf (ovf[i])
		);
	end

	side_t side_c6;
	side_t sd_s [DIV_LAT];
	assign side_c6 = '{rej: rej_s6, back: back_s6, dneg: dneg_s6,
		st_x: st_s6[0], st_y: st_s6[1], st_z: st_s6[2]};

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_c6;
			for (int k = 1; k < DIV_LAT; k++) sd_s[k] <= sd_s[k-1];
		end
	end

	side_t              sd_o;
	logic signed [31:0] st_o [3];
	logic signed [36:0] pt_c7 [3];
	logic signed [37:0] d_c7  [3];
	logic [2:0]         far_c7;
	assign sd_o    = sd_s[DIV_LAT-1];
	assign st_o[0] = sd_o.st_x;
	assign st_o[1] = sd_o.st_y;
	assign st_o[2] = sd_o.st_z;

	for (genvar i = 0; i < 3; i++) begin : g_pt
		assign pt_c7[i] = sd_o.dneg[i] ? 37'(st_o[i]) - $signed({2'b0, quo[i]})
			: 37'(st_o[i]) + $signed({2'b0, quo[i]});
		assign d_c7[i]  = 38'(pt_c7[i]) - 38'(center_q[i]);
		assign far_c7[i] = (d_c7[i] > 38'sd2147483647) || (d_c7[i] < -38'sd2147483647);
	end

	// Stages 7 to 9: point, squared distance, ring test.
	logic signed [36:0] pt_s7 [3], pt_s8 [3];
	logic [30:0]        ad_s7 [3];
	logic               rej_s7, rej_s8, back_s7, back_s8;
	logic [61:0]        sq_s8 [3];
	logic [61:0]        osq_s8, isq_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s7  <= sd_o.rej || ovf[0] || ovf[1] || ovf[2] || (far_c7 != '0);
			back_s7 <= sd_o.back;
			for (int i = 0; i < 3; i++) begin
				pt_s7[i] <= pt_c7[i];
				ad_s7[i] <= d_c7[i][37] ? 31'(-d_c7[i]) : d_c7[i][30:0];
			end
			rej_s8  <= rej_s7;
			back_s8 <= back_s7;
			osq_s8  <= outer_q * outer_q;
			isq_s8  <= inner_q * inner_q;
			for (int i = 0; i < 3; i++) begin
				pt_s8[i] <= pt_s7[i];
				sq_s8[i] <= ad_s7[i] * ad_s7[i];
			end
		end
	end

	logic [63:0] dsq;
	logic        hit_c;
	assign dsq   = 64'(sq_s8[0]) + 64'(sq_s8[1]) + 64'(sq_s8[2]);
	assign hit_c = !rej_s8 && (dsq <= 64'(osq_s8)) && (dsq >= 64'(isq_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			hit      <= hit_c;
			point_x  <= hit_c ? sat32(pt_s8[0]) : '0;
			point_y  <= hit_c ? sat32(pt_s8[1]) : '0;
			point_z  <= hit_c ? sat32(pt_s8[2]) : '0;
			facing_x <= hit_c ? (back_s8 ? neg_sat(nrm_q[0]) : nrm_q[0]) : '0;
			facing_y <= hit_c ? (back_s8 ? neg_sat(nrm_q[1]) : nrm_q[1]) : '0;
			facing_z <= hit_c ? (back_s8 ? neg_sat(nrm_q[2]) : nrm_q[2]) : '0;
		end
	end

endmodule

FILE: rtl/ria_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ria_div
	import ria_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QB-1:0]    quo,
	output logic             ovf
);

	logic [DEN_W-1:0] rem_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic [QB-1:0]    low_s [QB+1];
	logic [QB-1:0]    q_s   [QB+1];
	logic             ovf_s [QB+1];

	// The quotient only needs QB bits; anything larger is flagged as overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(num[NUM_W-1:NUM_W-QB]);
			den_s[0] <= den;
			low_s[0] <= num[QB-1:0];
			q_s[0]   <= '0;
			ovf_s[0] <= DEN_W'(num[NUM_W-1:NUM_W-QB]) >= den;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_s[k-1], low_s[k-1][QB-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den_s[k-1]}) : trial[DEN_W-1:0];
				den_s[k] <= den_s[k-1];
				low_s[k] <= {low_s[k-1][QB-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][QB-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = q_s[QB];
	assign ovf = ovf_s[QB];

endmodule

FILE: rtl/ria_chk.sv
// Port-level checker for the ray/annulus intersection unit, with its bind.
module ria_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               wr_en,
	input logic [2:0]         wr_index,
	input logic [31:0]        wr_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [31:0] start_x,
	input logic signed [31:0] start_y,
	input logic signed [31:0] start_z,
	input logic signed [17:0] dir_x,
	input logic signed [17:0] dir_y,
	input logic signed [17:0] dir_z,
	input logic               out_valid,
	input logic               out_ready,
	input logic               hit,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic signed [17:0] facing_x,
	input logic signed [17:0] facing_y,
	input logic signed [17:0] facing_z
);

	// The pipeline takes a word exactly when it can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// A miss carries all-zero payload.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> point_x == 0 && point_y == 0 && point_z == 0
			&& facing_x == 0 && facing_y == 0 && facing_z == 0)
		else $error("miss word with nonzero payload");

	// A stalled result word holds its hit, point_x and facing_z values.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(point_x)
			&& $stable(facing_z))
		else $error("stalled result changed");

	// Nothing comes out right after reset.
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind ray_annulus_intersect_unit ria_chk u_ria_chk (.*);

FILE: test/ring_hit_checker.sv
// Checker that predicts and compares the results of the ray/annulus intersection unit.
module ring_hit_checker
	import ria_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               hit,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [17:0] facing_x,
	input  logic signed [17:0] facing_y,
	input  logic signed [17:0] facing_z,
	output int                 errors,
	output int                 pending
);

	localparam longint EPS_RAW = 1;
	localparam int     FRAC    = 16;
	localparam longint EPS     = EPS_RAW << FRAC;
	localparam logic [127:0] OFF_CAP = 128'd1 << 62;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [17:0] fx;
		logic signed [17:0] fy;
		logic signed [17:0] fz;
	} ring_res_t;

	logic [31:0] ring_regs [8];
	ring_res_t   expected_q [$];

	function automatic logic [31:0] reg_mask(input logic [2:0] idx);
		case (idx)
			REG_PLANE_NORMAL_X, REG_PLANE_NORMAL_Y, REG_PLANE_NORMAL_Z: return 32'h3FFFF;
			REG_OUTER_RADIUS, REG_INNER_RADIUS: return 32'h7FFFFFFF;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic ring_res_t ring_intersect(input longint st [3], input longint dv [3]);
		ring_res_t res;
		longint ctr [3];
		longint nrm [3];
		longint pt [3];
		longint ptn, dtn, aptn, adtn, off, dd, f;
		longint unsigned ad, dsq, orad, irad;
		logic [127:0] num, quo, lhs, rhs;
		res = '0;
		ptn = 0;
		dtn = 0;
		dsq = 0;
		for (int i = 0; i < 3; i++) begin
			ctr[i] = longint'($signed(ring_regs[i]));
			nrm[i] = longint'($signed(ring_regs[3 + i][17:0]));
			ptn += (st[i] - ctr[i]) * nrm[i];
			dtn += dv[i] * nrm[i];
		end
		aptn = ptn < 0 ? -ptn : ptn;
		adtn = dtn < 0 ? -dtn : dtn;
		if (dtn == 0 || adtn < EPS || aptn < EPS)
			return res;
		if (ptn == 0 || (ptn < 0) == (dtn < 0))
			return res;
		lhs = 128'(aptn) << FRAC;
		rhs = 128'(EPS_RAW) * 128'(adtn);
		if (lhs < rhs)
			return res;
		for (int i = 0; i < 3; i++) begin
			num = 128'(aptn) * 128'(dv[i] < 0 ? -dv[i] : dv[i]);
			quo = num / 128'(adtn);
			off = quo > OFF_CAP ? longint'(OFF_CAP) : longint'(quo[63:0]);
			pt[i] = dv[i] < 0 ? st[i] - off : st[i] + off;
			dd = pt[i] - ctr[i];
			ad = dd < 0 ? -dd : dd;
			if (ad >= (64'd1 << 31))
				return res;
			dsq += ad * ad;
		end
		orad = ring_regs[REG_OUTER_RADIUS][30:0];
		irad = ring_regs[REG_INNER_RADIUS][30:0];
		if (dsq > orad * orad || dsq < irad * irad)
			return res;
		res.hit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			f = nrm[i];
			if (dtn >= 0) begin
				f = -f;
				if (f > 131071)
					f = 131071;
			end
			if (pt[i] > 64'sd2147483647)
				pt[i] = 64'sd2147483647;
			else if (pt[i] < -64'sd2147483648)
				pt[i] = -64'sd2147483648;
			case (i)
				0: begin res.px = pt[i][31:0]; res.fx = f[17:0]; end
				1: begin res.py = pt[i][31:0]; res.fy = f[17:0]; end
				default: begin res.pz = pt[i][31:0]; res.fz = f[17:0]; end
			endcase
		end
		return res;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial errors = 0;
	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ring_res_t want;
		longint st [3];
		longint dv [3];
		if (!arst_n) begin
			ring_regs[0] = 0; ring_regs[1] = 0; ring_regs[2] = 0;
			ring_regs[3] = 0; ring_regs[4] = 0; ring_regs[5] = 32'd65536;
			ring_regs[6] = 32'd65536; ring_regs[7] = 0;
			expected_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				st[0] = start_x; st[1] = start_y; st[2] = start_z;
				dv[0] = dir_x; dv[1] = dir_y; dv[2] = dir_z;
				expected_q.push_back(ring_intersect(st, dv));
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected word, hit", hit, 0);
				end else begin
					want = expected_q.pop_front();
					if (hit !== want.hit) report("hit", hit, want.hit);
					if (point_x !== want.px) report("point_x", point_x, want.px);
					if (point_y !== want.py) report("point_y", point_y, want.py);
					if (point_z !== want.pz) report("point_z", point_z, want.pz);
					if (facing_x !== want.fx) report("facing_x", facing_x, want.fx);
					if (facing_y !== want.fy) report("facing_y", facing_y, want.fy);
					if (facing_z !== want.fz) report("facing_z", facing_z, want.fz);
				end
			end
			// Registers change only while the pipeline is empty, so applying them here is safe.
			if (wr_en)
				ring_regs[wr_index] = wr_data & reg_mask(wr_index);
		end
	end

endmodule

FILE: test/tb.sv
// Stimulus, configuration phases and verdict for the ray/annulus intersection unit.
module tb;
	import ria_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN       = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [2:0]         wr_index = '0;
	logic [31:0]        wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [17:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [17:0] facing_x, facing_y, facing_z;
	int                 errors, pending;
	int                 in_idle = 9, out_idle = 85;
	int                 quiet = 0;
	longint             ring_cfg [8];

	always #5 clk = ~clk;

	ray_annulus_intersect_unit dut (.*);
	ring_hit_checker chk (.*);

	always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_ray(input longint sx, sy, sz, dx, dy, dz);
		logic rdy;
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle);
		end
		in_valid <= 1'b1;
		start_x <= sx[31:0]; start_y <= sy[31:0]; start_z <= sz[31:0];
		dir_x <= dx[17:0]; dir_y <= dy[17:0]; dir_z <= dz[17:0];
		do begin
			@(negedge clk) rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// Empties the pipeline, then rewrites every ring register.
	// The first edge lets the checker record the last accepted word before pending is read.
	task automatic load_ring(input longint c0, c1, c2, n0, n1, n2, orad, irad);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
		ring_cfg[0] = c0; ring_cfg[1] = c1; ring_cfg[2] = c2;
		ring_cfg[3] = n0; ring_cfg[4] = n1; ring_cfg[5] = n2;
		ring_cfg[6] = orad; ring_cfg[7] = irad;
		for (int i = 0; i < 8; i++) begin
			wr_en <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data <= ring_cfg[i][31:0];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	function automatic longint rand_dir();
		return longint'($urandom_range(131072)) - 65536;
	endfunction

	// Aims a ray at a random point of the ring plane, near or across the ring.
	task automatic send_aimed_ray();
		longint n [3];
		longint w [3];
		longint u [3];
		longint dv [3];
		longint st [3];
		longint reach, span;
		for (int i = 0; i < 3; i++) begin
			n[i] = longint'($signed(ring_cfg[3 + i][17:0]));
			w[i] = rand_dir();
			dv[i] = rand_dir();
		end
		u[0] = (n[1] * w[2] - n[2] * w[1]) >>> 16;
		u[1] = (n[2] * w[0] - n[0] * w[2]) >>> 16;
		u[2] = (n[0] * w[1] - n[1] * w[0]) >>> 16;
		reach = (ring_cfg[6] & 64'h7FFFFFFF) * $urandom_range(140) / 100;
		span = $urandom_range(1 << 21, 1);
		for (int i = 0; i < 3; i++)
			st[i] = longint'($signed(ring_cfg[i][31:0])) + ((u[i] * reach) >>> 16)
				- ((span * dv[i]) >>> 16);
		send_ray(st[0], st[1], st[2], dv[0], dv[1], dv[2]);
	endtask

	task automatic send_noise_ray();
		longint dv [3];
		for (int i = 0; i < 3; i++)
			dv[i] = $urandom_range(3) == 0 ? longint'($signed(18'($urandom()))) : rand_dir();
		send_ray(longint'($signed($urandom())), longint'($signed($urandom())),
			longint'($signed($urandom())), dv[0], dv[1], dv[2]);
	endtask

	initial begin
		ring_cfg[0] = 0; ring_cfg[1] = 0; ring_cfg[2] = 0;
		ring_cfg[3] = 0; ring_cfg[4] = 0; ring_cfg[5] = 65536;
		ring_cfg[6] = 65536; ring_cfg[7] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rays against the reset ring: unit disk in the z = 0 plane.
		send_ray(0, 0, 5 << 16, 0, 0, -65536);
		send_ray(65536, 0, 2 << 16, 0, 0, -65536);
		send_ray(65537, 0, 2 << 16, 0, 0, -65536);
		send_ray(0, 30000, -(3 << 16), 0, 0, 65536);
		send_ray(0, 0, 5 << 16, 0, 0, 0);
		send_ray(0, 0, 5 << 16, 65536, 0, 0);
		send_ray(0, 0, 0, 0, 0, -65536);
		send_ray(0, 0, 1, 0, 0, -65536);
		send_ray(0, 0, 5 << 16, 0, 0, 65536);
		send_ray(0, 0, 5 << 16, 0, 0, -1);
		send_ray(0, 0, 100, 65536, -65536, -1);
		send_ray(-20000, 20000, 3 << 16, 10000, -10000, -65536);
		send_ray(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 65536, 65536, 65536);
		send_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, -65536, -65536, -65536);
		send_ray(32'sh7FFFFFFF, -64'sd2147483648, 32'sh7FFFFFFF, -65536, 65536, -65536);
		send_ray(0, 0, 32'sh7FFFFFFF, 65536, 65536, -1);
		send_ray(0, 0, -64'sd2147483648, -65536, 65536, 1);
		send_ray(0, 0, 65536, 0, 0, -131072);
		send_ray(0, 0, 65536, 131071, 0, -65536);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_ring(98304, -131072, 16384, 0, 0, 65536, 10 << 16, 3 << 16);
				1: load_ring(longint'($signed($urandom_range(1 << 24))), -77777, 1 << 20,
					-65536, 0, 0, 32'h7FFFFFFF, 0);
				2: load_ring(5 << 16, 0, -(7 << 16), 46341, 0, 46341, 5 << 16, 8 << 16);
				3: load_ring(0, 0, 0, 0, 65536, 0, 64 << 16, 2 << 16);
				default: load_ring(32'h80000000, 32'h7FFFFFFF, 0, 32'h20000, 65536, -65536,
					32'h7FFFFFFF, 32'h7FFFFFFF);
			endcase
			if (phase == 2) begin
				in_idle = 85;
				out_idle = 9;
			end else if (phase == 4) begin
				in_idle = 0;
				out_idle = 0;
			end
			repeat (90) begin
				if ($urandom_range(99) < 70)
					send_aimed_ray();
				else
					send_noise_ray();
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
